FILE: sv/cwp_pkg.sv
// Shared types and constants for the two-way cache tag directory with way prediction.
// Word structs for request and result, per-set state row, config register codes.
// No dependencies.
`default_nettype none

package cwp_pkg;

  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 4;

  localparam logic [CFG_IDX_W-1:0] CFG_SET_BITS    = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_OFFSET_BITS = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_PRED_BITS   = 2'd2;

  localparam logic [CFG_DATA_W-1:0] RST_SET_BITS    = 4'd8;
  localparam logic [CFG_DATA_W-1:0] RST_OFFSET_BITS = 4'd6;
  localparam logic [CFG_DATA_W-1:0] RST_PRED_BITS   = 4'd10;

  localparam int OFFSET_MIN = 3;
  localparam int OFFSET_MAX = 9;
  localparam int SET_MIN    = 1;
  // smallest set + offset split; sets the stored tag width
  localparam int SPLIT_MIN  = SET_MIN + OFFSET_MIN;

  localparam logic REQ_LOAD  = 1'b0;
  localparam logic REQ_STORE = 1'b1;

  typedef struct packed {
    logic        req_type;
    logic [63:0] address;
  } req_t;

  typedef struct packed {
    logic hit;
    logic way;
    logic writeback;
    logic predicted_way;
    logic mispredict;
  } result_t;

  // per-set directory state kept beside the two tags
  typedef struct packed {
    logic lru;
    logic valid1;
    logic dirty1;
    logic valid0;
    logic dirty0;
  } set_state_t;

  typedef struct packed {
    logic [CFG_DATA_W-1:0] set_bits;
    logic [CFG_DATA_W-1:0] offset_bits;
    logic [CFG_DATA_W-1:0] pred_bits;
  } split_cfg_t;

  function automatic logic [CFG_DATA_W-1:0] clamp_cfg(
    input logic [CFG_DATA_W-1:0] v,
    input int                    lo,
    input int                    hi
  );
    logic [CFG_DATA_W-1:0] r;
    r = v;
    if (int'(v) < lo) r = CFG_DATA_W'(lo);
    else if (int'(v) > hi) r = CFG_DATA_W'(hi);
    return r;
  endfunction

endpackage

`default_nettype wire

FILE: sv/cwp_split.sv
// Address splitter: strips the block offset and gives set index, tag and predictor index.
// Uses cwp_pkg for the split config struct.
`default_nettype none

module cwp_split #(
  parameter int ADDR_W = 64,
  parameter int SET_W  = 8,
  parameter int PIDX_W = 10,
  parameter int TAG_W  = 60
) (
  input  wire logic [ADDR_W-1:0]   addr,
  input  wire cwp_pkg::split_cfg_t cfg,
  output logic [SET_W-1:0]         set_idx,
  output logic [TAG_W-1:0]         tag,
  output logic [PIDX_W-1:0]        pidx
);
  import cwp_pkg::*;

  logic [ADDR_W-1:0] blk;
  logic [ADDR_W-1:0] set_mask;
  logic [ADDR_W-1:0] pred_mask;
  logic [ADDR_W-1:0] tag_full;
  logic [ADDR_W-1:0] set_full;
  logic [ADDR_W-1:0] pred_full;
  logic [CFG_DATA_W:0] tag_shift;

  always_comb begin
    blk       = addr >> cfg.offset_bits;
    set_mask  = ~({ADDR_W{1'b1}} << cfg.set_bits);
    pred_mask = ~({ADDR_W{1'b1}} << cfg.pred_bits);
    tag_shift = {1'b0, cfg.set_bits} + {1'b0, cfg.offset_bits};
    tag_full  = addr >> tag_shift;
    set_full  = blk & set_mask;
    pred_full = blk & pred_mask;
    set_idx   = set_full[SET_W-1:0];
    tag       = tag_full[TAG_W-1:0];
    pidx      = pred_full[PIDX_W-1:0];
  end

endmodule

`default_nettype wire

FILE: sv/cwp_dir.sv
// Directory memory: one row per set holding state bits and both way tags.
// Synchronous, one write and one registered read per cycle. Uses cwp_pkg.
`default_nettype none

module cwp_dir #(
  parameter int SET_W = 8,
  parameter int TAG_W = 60
) (
  input  wire logic                   clk,
  input  wire logic                   rd_en,
  input  wire logic [SET_W-1:0]       rd_set,
  output cwp_pkg::set_state_t         rd_state,
  output logic [TAG_W-1:0]            rd_tag0,
  output logic [TAG_W-1:0]            rd_tag1,
  input  wire logic                   wr_en,
  input  wire logic [SET_W-1:0]       wr_set,
  input  wire cwp_pkg::set_state_t    wr_state,
  input  wire logic [TAG_W-1:0]       wr_tag0,
  input  wire logic [TAG_W-1:0]       wr_tag1
);
  import cwp_pkg::*;

  localparam int ROW_W = $bits(set_state_t) + 2 * TAG_W;

  logic [ROW_W-1:0] mem [2**SET_W];
  logic [ROW_W-1:0] rd_row;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_set] <= {wr_state, wr_tag1, wr_tag0};
    end
    if (rd_en) begin
      rd_row <= mem[rd_set];
    end
  end

  assign {rd_state, rd_tag1, rd_tag0} = rd_row;

endmodule

`default_nettype wire

FILE: sv/cwp_pred.sv
// Way predictor memory: one bit per entry, indexed by low block address bits.
// Synchronous, one write and one registered read per cycle.
`default_nettype none

module cwp_pred #(
  parameter int PIDX_W = 10
) (
  input  wire logic              clk,
  input  wire logic              rd_en,
  input  wire logic [PIDX_W-1:0] rd_idx,
  output logic                   rd_way,
  input  wire logic              wr_en,
  input  wire logic [PIDX_W-1:0] wr_idx,
  input  wire logic              wr_way
);

  logic mem [2**PIDX_W];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_idx] <= wr_way;
    end
    if (rd_en) begin
      rd_way <= mem[rd_idx];
    end
  end

endmodule

`default_nettype wire

FILE: sv/two_way_cache_with_way_predict_unit.sv
// Top level: two-way set-associative tag directory with LRU and way prediction.
// Uses cwp_pkg, cwp_split, cwp_dir and cwp_pred.
`default_nettype none

// One access is taken when start is high and busy is low; its result appears
// on result, after the registered directory read and the lookup state, with done
// high for exactly one cycle, and must be captured then. An access has a step for
// the synchronous read of the directory row and predictor entry, then a step to
// compare tags and write the updated row back, so a new access can be started
// once busy falls again as done rises. After reset busy stays high for a clearing
// pass over every value of a max(SET_BITS_MAX, PRED_BITS_MAX)-bit counter that
// zeroes the directory state and predictor; config writes are taken at any
// time but should only be issued while no access is in flight.
module two_way_cache_with_way_predict_unit #(
  parameter int SET_BITS_MAX  = 8,
  parameter int PRED_BITS_MAX = 10,
  parameter int ADDR_WIDTH    = 64
) (
  input  wire logic                               clk,
  input  wire logic                               rst,
  input  wire logic                               start,
  output logic                                    busy,
  input  wire cwp_pkg::req_t                      req,
  output logic                                    done,
  output cwp_pkg::result_t                        result,
  input  wire logic                               cfg_valid,
  output logic                                    cfg_ready,
  input  wire logic [cwp_pkg::CFG_IDX_W-1:0]      cfg_index,
  input  wire logic [cwp_pkg::CFG_DATA_W-1:0]     cfg_data
);
  import cwp_pkg::*;

  localparam int SET_W  = SET_BITS_MAX;
  localparam int PIDX_W = (PRED_BITS_MAX > 0) ? PRED_BITS_MAX : 1;
  localparam int TAG_W  = ADDR_WIDTH - SPLIT_MIN;
  localparam int CLR_W  = (SET_W > PIDX_W) ? SET_W : PIDX_W;

  typedef enum logic [2:0] {
    ST_CLEAR = 3'b001,
    ST_IDLE  = 3'b010,
    ST_LOOK  = 3'b100
  } state_t;

  state_t     state, state_next;
  logic [CLR_W-1:0] clr_cnt;
  split_cfg_t cfg;

  logic accept;
  logic [SET_W-1:0]  in_set;
  logic [TAG_W-1:0]  in_tag;
  logic [PIDX_W-1:0] in_pidx;

  logic              store_q;
  logic [SET_W-1:0]  set_q;
  logic [TAG_W-1:0]  tag_q;
  logic [PIDX_W-1:0] pidx_q;

  set_state_t        rd_state;
  logic [TAG_W-1:0]  rd_tag0, rd_tag1;
  logic              pred_way;

  logic              hit0, hit1, hit, way, wb, mis;
  set_state_t        new_state;
  logic [TAG_W-1:0]  new_tag0, new_tag1;

  logic              dir_we;
  logic [SET_W-1:0]  dir_wset;
  set_state_t        dir_wstate;
  logic [TAG_W-1:0]  dir_wtag0, dir_wtag1;
  logic              pred_we;
  logic [PIDX_W-1:0] pred_widx;
  logic              pred_wway;

  assign busy      = (state != ST_IDLE);
  assign accept    = start && !busy;
  assign cfg_ready = 1'b1;

  // config registers, saturated on write
  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.set_bits    <= clamp_cfg(RST_SET_BITS, SET_MIN, SET_BITS_MAX);
      cfg.offset_bits <= clamp_cfg(RST_OFFSET_BITS, OFFSET_MIN, OFFSET_MAX);
      cfg.pred_bits   <= clamp_cfg(RST_PRED_BITS, 0, PRED_BITS_MAX);
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_index)
        CFG_SET_BITS:    cfg.set_bits    <= clamp_cfg(cfg_data, SET_MIN, SET_BITS_MAX);
        CFG_OFFSET_BITS: cfg.offset_bits <= clamp_cfg(cfg_data, OFFSET_MIN, OFFSET_MAX);
        CFG_PRED_BITS:   cfg.pred_bits   <= clamp_cfg(cfg_data, 0, PRED_BITS_MAX);
        default: ;
      endcase
    end
  end

  cwp_split #(
    .ADDR_W (ADDR_WIDTH),
    .SET_W  (SET_W),
    .PIDX_W (PIDX_W),
    .TAG_W  (TAG_W)
  ) u_split (
    .addr    (req.address[ADDR_WIDTH-1:0]),
    .cfg     (cfg),
    .set_idx (in_set),
    .tag     (in_tag),
    .pidx    (in_pidx)
  );

  cwp_dir #(
    .SET_W (SET_W),
    .TAG_W (TAG_W)
  ) u_dir (
    .clk      (clk),
    .rd_en    (accept),
    .rd_set   (in_set),
    .rd_state (rd_state),
    .rd_tag0  (rd_tag0),
    .rd_tag1  (rd_tag1),
    .wr_en    (dir_we),
    .wr_set   (dir_wset),
    .wr_state (dir_wstate),
    .wr_tag0  (dir_wtag0),
    .wr_tag1  (dir_wtag1)
  );

  cwp_pred #(
    .PIDX_W (PIDX_W)
  ) u_pred (
    .clk    (clk),
    .rd_en  (accept),
    .rd_idx (in_pidx),
    .rd_way (pred_way),
    .wr_en  (pred_we),
    .wr_idx (pred_widx),
    .wr_way (pred_wway)
  );

  always_ff @(posedge clk) begin
    if (accept) begin
      store_q <= (req.req_type == REQ_STORE);
      set_q   <= in_set;
      tag_q   <= in_tag;
      pidx_q  <= in_pidx;
    end
  end

  // lookup and update of the row read last cycle
  always_comb begin
    hit0 = rd_state.valid0 && (rd_tag0 == tag_q);
    hit1 = rd_state.valid1 && (rd_tag1 == tag_q);
    hit  = hit0 || hit1;
    if (hit0) way = 1'b0;
    else if (hit1) way = 1'b1;
    else way = rd_state.lru;
    wb  = !hit && (way ? (rd_state.valid1 && rd_state.dirty1)
                       : (rd_state.valid0 && rd_state.dirty0));
    mis = hit && (way != pred_way);

    new_state     = rd_state;
    new_state.lru = ~way;
    new_tag0      = rd_tag0;
    new_tag1      = rd_tag1;
    if (way) begin
      new_state.valid1 = 1'b1;
      new_state.dirty1 = hit ? (rd_state.dirty1 || store_q) : store_q;
      if (!hit) new_tag1 = tag_q;
    end else begin
      new_state.valid0 = 1'b1;
      new_state.dirty0 = hit ? (rd_state.dirty0 || store_q) : store_q;
      if (!hit) new_tag0 = tag_q;
    end
  end

  // write port: clearing sweep after reset, otherwise lookup write-back
  always_comb begin
    dir_we     = 1'b0;
    dir_wset   = set_q;
    dir_wstate = new_state;
    dir_wtag0  = new_tag0;
    dir_wtag1  = new_tag1;
    pred_we    = 1'b0;
    pred_widx  = pidx_q;
    pred_wway  = way;
    unique case (state)
      ST_CLEAR: begin
        dir_we     = 1'b1;
        dir_wset   = clr_cnt[SET_W-1:0];
        dir_wstate = '0;
        dir_wtag0  = '0;
        dir_wtag1  = '0;
        pred_we    = 1'b1;
        pred_widx  = clr_cnt[PIDX_W-1:0];
        pred_wway  = 1'b0;
      end
      ST_LOOK: begin
        dir_we  = 1'b1;
        pred_we = !hit || mis;
      end
      default: ;
    endcase
  end

  always_comb begin
    state_next = state;
    unique case (state)
      ST_CLEAR: if (clr_cnt == {CLR_W{1'b1}}) state_next = ST_IDLE;
      ST_IDLE:  if (accept) state_next = ST_LOOK;
      ST_LOOK:  state_next = ST_IDLE;
      default:  state_next = ST_CLEAR;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state   <= ST_CLEAR;
      clr_cnt <= '0;
      done    <= 1'b0;
    end else begin
      state   <= state_next;
      done    <= (state == ST_LOOK);
      if (state == ST_CLEAR) clr_cnt <= clr_cnt + 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (state == ST_LOOK) begin
      result.hit           <= hit;
      result.way           <= way;
      result.writeback     <= wb;
      result.predicted_way <= pred_way;
      result.mispredict    <= mis;
    end
  end

`ifndef NO_ASSERTIONS
  a_done_follows_look: assert property (@(posedge clk) disable iff (rst)
    done |-> $past(state == ST_LOOK))
    else $error("done without a lookup cycle");

  a_accept_to_look: assert property (@(posedge clk) disable iff (rst)
    accept |=> (state == ST_LOOK) && busy)
    else $error("accepted word did not enter lookup");

  a_result_flags: assert property (@(posedge clk) disable iff (rst)
    done |-> !(result.hit && result.writeback) && !(!result.hit && result.mispredict))
    else $error("writeback on hit or mispredict on miss");

  a_look_done: assert property (@(posedge clk) disable iff (rst)
    (state == ST_LOOK) |=> done && !busy)
    else $error("lookup did not complete in one cycle");
`endif

endmodule

`default_nettype wire

FILE: tb/cwp_dir_checker.sv
// Scoreboard for the two-way cache tag directory: watches the access, result and
// register channels, keeps its own directory/predictor state and compares results.
// Depends on cwp_pkg.
`timescale 1ns / 100ps

module cwp_dir_checker #(
  parameter int SET_BITS_MAX  = 8,
  parameter int PRED_BITS_MAX = 10
) (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           start,
  input  logic                           busy,
  input  cwp_pkg::req_t                  req,
  input  logic                           done,
  input  cwp_pkg::result_t               result,
  input  logic                           cfg_valid,
  input  logic                           cfg_ready,
  input  logic [cwp_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [cwp_pkg::CFG_DATA_W-1:0] cfg_data,
  output int                             outstanding,
  output int                             failures
);
  import cwp_pkg::*;

  localparam int NUM_SETS  = 1 << SET_BITS_MAX;
  localparam int NUM_GUESS = 1 << PRED_BITS_MAX;

  logic [63:0] dir_tag   [2*NUM_SETS];
  bit          dir_valid [2*NUM_SETS];
  bit          dir_dirty [2*NUM_SETS];
  bit          set_lru   [NUM_SETS];
  bit          way_guess [NUM_GUESS];

  logic [CFG_DATA_W-1:0] set_bits_r, offset_bits_r, pred_bits_r;

  result_t expected_results[$];
  result_t want;
  int      mismatches = 0;

  function automatic int clamp_width(input logic [CFG_DATA_W-1:0] v, input int lo,
                                     input int hi);
    if (int'(v) < lo) return lo;
    if (int'(v) > hi) return hi;
    return int'(v);
  endfunction

  // Looks up one access, updates the directory and predictor, returns the result word.
  function automatic result_t lookup_directory(input req_t r);
    int          s, b, p, set_n, pidx, base;
    logic [63:0] blk, tag;
    logic        hit0, hit1, w;
    result_t     res;
    s     = clamp_width(set_bits_r, SET_MIN, SET_BITS_MAX);
    b     = clamp_width(offset_bits_r, OFFSET_MIN, OFFSET_MAX);
    p     = clamp_width(pred_bits_r, 0, PRED_BITS_MAX);
    blk   = r.address >> b;
    set_n = int'(blk & ((64'd1 << s) - 64'd1));
    tag   = r.address >> (s + b);
    pidx  = int'(blk & ((64'd1 << p) - 64'd1));
    base  = 2 * set_n;
    res   = '0;
    res.predicted_way = way_guess[pidx];
    hit0 = dir_valid[base] && (dir_tag[base] == tag);
    hit1 = dir_valid[base+1] && (dir_tag[base+1] == tag);
    if (hit0 || hit1) begin
      w = hit0 ? 1'b0 : 1'b1;
      res.hit = 1'b1;
      res.way = w;
      set_lru[set_n] = ~w;
      if (r.req_type == REQ_STORE) dir_dirty[base+int'(w)] = 1'b1;
      if (w != way_guess[pidx]) begin
        res.mispredict  = 1'b1;
        way_guess[pidx] = w;
      end
    end else begin
      // LRU way is the victim; predictor trained to the filled way
      w = set_lru[set_n];
      res.way       = w;
      res.writeback = dir_valid[base+int'(w)] && dir_dirty[base+int'(w)];
      dir_tag[base+int'(w)]   = tag;
      dir_valid[base+int'(w)] = 1'b1;
      dir_dirty[base+int'(w)] = (r.req_type == REQ_STORE);
      set_lru[set_n]  = ~w;
      way_guess[pidx] = w;
    end
    return res;
  endfunction

  always @(posedge clk) begin
    if (rst) begin
      foreach (dir_valid[i]) begin
        dir_valid[i] = 1'b0;
        dir_dirty[i] = 1'b0;
      end
      foreach (set_lru[i]) set_lru[i] = 1'b0;
      foreach (way_guess[i]) way_guess[i] = 1'b0;
      set_bits_r    = RST_SET_BITS;
      offset_bits_r = RST_OFFSET_BITS;
      pred_bits_r   = RST_PRED_BITS;
      expected_results.delete();
    end else begin
      if (done === 1'b1) begin
        if (expected_results.size() == 0) begin
          mismatches++;
          if (mismatches <= 10)
            $display("%0t: result word with no access pending: %p", $time, result);
        end else begin
          want = expected_results.pop_front();
          if (result.hit !== want.hit || result.way !== want.way ||
              result.writeback !== want.writeback ||
              result.predicted_way !== want.predicted_way ||
              result.mispredict !== want.mispredict) begin
            mismatches++;
            if (mismatches <= 10)
              $display("%0t: result mismatch: expected %p, got %p", $time, want, result);
          end
        end
      end
      // an access taken at this edge still sees the old split
      if (start === 1'b1 && busy === 1'b0)
        expected_results.push_back(lookup_directory(req));
      if (cfg_valid && cfg_ready) begin
        case (cfg_index)
          CFG_SET_BITS:    set_bits_r    = cfg_data;
          CFG_OFFSET_BITS: offset_bits_r = cfg_data;
          CFG_PRED_BITS:   pred_bits_r   = cfg_data;
          default: ;
        endcase
      end
    end
    outstanding <= expected_results.size();
    failures    <= mismatches;
  end

endmodule

FILE: tb/two_way_cache_with_way_predict_unit_tb.sv
// Stimulus and verdict for the two-way cache tag directory with way prediction.
// Drives accesses and register writes; checking lives in cwp_dir_checker. Uses cwp_pkg.
`timescale 1ns / 100ps

module two_way_cache_with_way_predict_unit_tb;
  import cwp_pkg::*;

  localparam int RUN_LIMIT = 150000;
  localparam int PHASES    = 10;
  localparam int PHASE_LEN = 55;
  // register index past the end of the list; writes to it are ignored
  localparam logic [CFG_IDX_W-1:0] CFG_UNUSED = 2'd3;

  logic                  clk = 1'b0;
  logic                  rst;
  logic                  start;
  logic                  busy;
  req_t                  req;
  logic                  done;
  result_t               result;
  logic                  cfg_valid;
  logic                  cfg_ready;
  logic [CFG_IDX_W-1:0]  cfg_index;
  logic [CFG_DATA_W-1:0] cfg_data;
  int                    outstanding;
  int                    failures;
  int                    cycle_count = 0;
  bit                    no_idle;
  logic [63:0]           recent_addrs[$];
  logic [63:0]           hot_bases[4];

  two_way_cache_with_way_predict_unit dut (
    .clk(clk), .rst(rst), .start(start), .busy(busy), .req(req), .done(done),
    .result(result), .cfg_valid(cfg_valid), .cfg_ready(cfg_ready),
    .cfg_index(cfg_index), .cfg_data(cfg_data)
  );

  cwp_dir_checker u_checker (
    .clk(clk), .rst(rst), .start(start), .busy(busy), .req(req), .done(done),
    .result(result), .cfg_valid(cfg_valid), .cfg_ready(cfg_ready),
    .cfg_index(cfg_index), .cfg_data(cfg_data), .outstanding(outstanding),
    .failures(failures)
  );

  always #5 clk = ~clk;

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= RUN_LIMIT) begin
      $display("Mismatches found");
      $finish;
    end
  end

  // start stays high into the next access when no gap is drawn
  task automatic issue_access(input logic kind, input logic [63:0] addr);
    int gap;
    start       <= 1'b1;
    req         <= '{req_type: kind, address: addr};
    @(posedge clk);
    while (busy) @(posedge clk);
    gap = no_idle ? 0 : $urandom_range(0, 17);
    if (gap != 0) begin
      start <= 1'b0;
      repeat (gap) @(posedge clk);
    end
  endtask

  task automatic drain;
    start <= 1'b0;
    repeat (2) @(posedge clk);
    while (outstanding != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] val,
                           input bit last);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    if (last) cfg_valid <= 1'b0;
  endtask

  function automatic logic [CFG_DATA_W-1:0] draw_reg(input int lo, input int hi);
    int pick;
    pick = $urandom_range(0, 9);
    if (pick < 2) return CFG_DATA_W'(lo);
    if (pick < 4) return CFG_DATA_W'(hi);
    return CFG_DATA_W'($urandom_range(0, 15));
  endfunction

  // mostly reuse of recent blocks and near neighbors, so sets fill and conflict
  function automatic logic [63:0] pick_address();
    logic [63:0] a;
    int          mode, span;
    mode = $urandom_range(0, 99);
    if (mode < 45 && recent_addrs.size() != 0) begin
      a = recent_addrs[$urandom_range(0, recent_addrs.size() - 1)] ^ 64'($urandom_range(0, 7));
    end else if (mode < 80) begin
      span = $urandom_range(4, 18);
      a = hot_bases[$urandom_range(0, 3)] ^ ({$urandom, $urandom} & ((64'd1 << span) - 64'd1));
    end else begin
      a = {$urandom, $urandom};
    end
    recent_addrs.push_back(a);
    if (recent_addrs.size() > 16) void'(recent_addrs.pop_front());
    return a;
  endfunction

  initial begin
    rst       <= 1'b1;
    start     <= 1'b0;
    req       <= '0;
    cfg_valid <= 1'b0;
    cfg_index <= CFG_SET_BITS;
    cfg_data  <= '0;
    no_idle   = 1'b0;
    hot_bases[0] = '0;
    hot_bases[1] = '1;
    hot_bases[2] = {$urandom, $urandom};
    hot_bases[3] = {$urandom, $urandom};
    repeat (5) @(posedge clk);
    rst <= 1'b0;

    // reset split, empty directory
    issue_access(REQ_LOAD, 64'd0);
    issue_access(REQ_STORE, '1);
    issue_access(REQ_LOAD, 64'd0);
    drain();

    // below-range writes saturate to the smallest split, one predictor entry
    write_reg(CFG_SET_BITS, 4'd0, 1'b0);
    write_reg(CFG_OFFSET_BITS, 4'd0, 1'b0);
    write_reg(CFG_PRED_BITS, 4'd0, 1'b0);
    write_reg(CFG_UNUSED, 4'hF, 1'b1);
    issue_access(REQ_STORE, 64'h00);
    issue_access(REQ_LOAD, 64'h10);
    issue_access(REQ_LOAD, 64'h00);  // hit in way 0 while predictor says way 1
    issue_access(REQ_LOAD, 64'h20);  // evicts the clean block in way 1
    issue_access(REQ_LOAD, 64'h10);  // evicts the dirty block
    issue_access(REQ_STORE, 64'h18);
    issue_access(REQ_LOAD, 64'h08);
    issue_access(REQ_STORE, 64'h28);
    issue_access(REQ_LOAD, 64'h48);
    issue_access(REQ_LOAD, 64'hFFFF_FFFF_FFFF_FFF8);
    issue_access(REQ_STORE, '1);
    drain();

    // above-range writes saturate to the largest split; contents kept
    write_reg(CFG_SET_BITS, 4'hF, 1'b0);
    write_reg(CFG_OFFSET_BITS, 4'hF, 1'b0);
    write_reg(CFG_PRED_BITS, 4'hF, 1'b1);
    issue_access(REQ_LOAD, 64'd0);
    issue_access(REQ_STORE, '1);
    issue_access(REQ_LOAD, 64'h8000_0000_0000_0000);
    issue_access(REQ_STORE, 64'h1FF);
    issue_access(REQ_LOAD, '1);
    drain();

    for (int ph = 0; ph < PHASES; ph++) begin
      write_reg(CFG_SET_BITS, draw_reg(SET_MIN, 8), 1'b0);
      write_reg(CFG_OFFSET_BITS, draw_reg(OFFSET_MIN, OFFSET_MAX), 1'b0);
      if ($urandom_range(0, 3) == 0) begin
        write_reg(CFG_PRED_BITS, draw_reg(0, 10), 1'b0);
        write_reg(CFG_UNUSED, CFG_DATA_W'($urandom_range(0, 15)), 1'b1);
      end else begin
        write_reg(CFG_PRED_BITS, draw_reg(0, 10), 1'b1);
      end
      no_idle = ($urandom_range(0, 3) == 0);
      for (int n = 0; n < PHASE_LEN; n++)
        issue_access(logic'($urandom_range(0, 1)), pick_address());
      drain();
    end

    repeat (10) @(posedge clk);
    if (failures == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end

endmodule
